>>> rtl/pxa_pkg.sv
// ============================================================================
// pxa_pkg
// Shared types and constants for the pixel to ASCII mapper.
// ============================================================================
package pxa_pkg;

    // Image geometry
    localparam int MAX_DIM     = 4096;
    localparam int POS_W       = $clog2(MAX_DIM);
    localparam int EFF_W       = POS_W + 1;
    localparam int CFG_DIM_W   = 13;

    // Ramp
    localparam int RAMP_LEVELS = 10;
    localparam int LEVEL_W     = $clog2(RAMP_LEVELS);
    localparam int CHAR_W      = 7;

    // Arithmetic widths
    localparam int COMP_W      = 8;
    localparam int SQ_W        = 2 * COMP_W;
    localparam int ACC_W       = 32;
    localparam int Q_W         = 16;
    localparam int SCALED_W    = Q_W + COMP_W;
    localparam int RECIP_W     = 25;
    localparam int DIV_PROD_W  = SCALED_W + RECIP_W;
    localparam int DIV_SHIFT   = 32;
    localparam int MAC_STEPS   = 3;

    // Q16 luminance weights, red / green / blue
    localparam logic [SQ_W-1:0] WEIGHTS [MAC_STEPS] = '{16'd19595, 16'd38470, 16'd7471};

    // ceil(2^32 / 255); exact floor division for products below 2^32/254
    localparam logic [RECIP_W-1:0] RECIP_255 = 25'd16843010;

    // Level k starts at ceil(k * 2551 * 256 / 100) in Q8 brightness
    localparam logic [Q_W-1:0] LEVEL_THR [RAMP_LEVELS-1] = '{
        16'd6531,  16'd13062, 16'd19592, 16'd26123, 16'd32653,
        16'd39184, 16'd45714, 16'd52245, 16'd58776
    };

    // Character ramps: "@%#*+=-:. " and its reverse
    localparam logic [CHAR_W-1:0] RAMP_DARK [RAMP_LEVELS] = '{
        7'h40, 7'h25, 7'h23, 7'h2A, 7'h2B, 7'h3D, 7'h2D, 7'h3A, 7'h2E, 7'h20
    };
    localparam logic [CHAR_W-1:0] RAMP_LIGHT [RAMP_LEVELS] = '{
        7'h20, 7'h2E, 7'h3A, 7'h2D, 7'h3D, 7'h2B, 7'h2A, 7'h23, 7'h25, 7'h40
    };

    localparam logic [CHAR_W-1:0] CHAR_NL  = 7'h0A;
    localparam logic [CHAR_W-1:0] CHAR_NUL = 7'h00;

    // Register map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_ROW_WIDTH = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_INVERT    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_USE_ALPHA = 2'd3;

    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } ascii_t;

    // One classified pixel handed from front to back
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              eol;
        logic              eoi;
    } token_t;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] row_width;
        logic [CFG_DIM_W-1:0] row_count;
        logic                 invert;
        logic                 use_alpha;
    } cfg_t;

    // Zero acts as one, oversize clamps to MAX_DIM
    function automatic logic [EFF_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        if (wide == 32'd0)
        begin
            wide = 32'd1;
        end
        else if (wide > 32'(MAX_DIM))
        begin
            wide = 32'(MAX_DIM);
        end
        return EFF_W'(wide);
    endfunction

endpackage

>>> rtl/pxa_front.sv
// ============================================================================
// pxa_front
// Accepts pixels, tracks row/column position and computes the ramp character
// with a multi-cycle sequencer (MAC, bit-serial square root, alpha scale).
// ============================================================================
module pxa_front (
    input  logic              clk,
    input  logic              rst_n,
    input  pxa_pkg::cfg_t     cfg,
    input  logic              pixel_valid,
    output logic              pixel_ready,
    input  pxa_pkg::pixel_t   pixel,
    output logic              tok_valid,
    input  logic              tok_ready,
    output pxa_pkg::token_t   tok
);

    localparam int STEP_W = $clog2(pxa_pkg::Q_W);
    localparam int MIDX_W = $clog2(pxa_pkg::MAC_STEPS);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MAC    = 6'b000010,
        ST_ROOT   = 6'b000100,
        ST_SCALE  = 6'b001000,
        ST_DIVIDE = 6'b010000,
        ST_PUSH   = 6'b100000
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [pxa_pkg::POS_W-1:0] col_reg, col_next;
    logic [pxa_pkg::POS_W-1:0] row_reg, row_next;
    logic eol_reg, eol_next;
    logic eoi_reg, eoi_next;

    logic [pxa_pkg::SQ_W-1:0]     sq_reg [pxa_pkg::MAC_STEPS];
    logic [pxa_pkg::SQ_W-1:0]     sq_next [pxa_pkg::MAC_STEPS];
    logic [pxa_pkg::COMP_W-1:0]   alpha_reg, alpha_next;
    logic [pxa_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [pxa_pkg::Q_W-1:0]      root_reg, root_next;
    logic [pxa_pkg::SCALED_W-1:0] scaled_reg, scaled_next;
    logic [pxa_pkg::Q_W-1:0]      bright_reg, bright_next;

    logic                         accept;
    logic [pxa_pkg::EFF_W-1:0]    eff_w, eff_h;
    logic                         col_end, row_end;
    logic [MIDX_W-1:0]            mac_idx;
    logic [pxa_pkg::Q_W-1:0]      trial;
    logic [pxa_pkg::ACC_W-1:0]    trial_sq;
    logic [pxa_pkg::DIV_PROD_W-1:0] div_prod;
    logic [pxa_pkg::LEVEL_W-1:0]  level;

    assign pixel_ready = (state_reg == ST_IDLE);
    assign accept      = pixel_valid && pixel_ready;

    // Position classification
    assign eff_w   = pxa_pkg::eff_dim(cfg.row_width);
    assign eff_h   = pxa_pkg::eff_dim(cfg.row_count);
    assign col_end = (pxa_pkg::EFF_W'(col_reg) + pxa_pkg::EFF_W'(1)) >= eff_w;
    assign row_end = (pxa_pkg::EFF_W'(row_reg) + pxa_pkg::EFF_W'(1)) >= eff_h;

    // Datapath operands
    assign mac_idx  = step_reg[MIDX_W-1:0];
    assign trial    = root_reg | (pxa_pkg::Q_W'(1) << step_reg);
    assign trial_sq = pxa_pkg::ACC_W'(trial) * pxa_pkg::ACC_W'(trial);
    assign div_prod = pxa_pkg::DIV_PROD_W'(scaled_reg)
                    * pxa_pkg::DIV_PROD_W'(pxa_pkg::RECIP_255);

    // Level quantize and ramp lookup
    always_comb
    begin
        level = '0;
        for (int k = 0; k < pxa_pkg::RAMP_LEVELS - 1; k++)
        begin
            if (bright_reg >= pxa_pkg::LEVEL_THR[k])
            begin
                level = pxa_pkg::LEVEL_W'(k + 1);
            end
        end
    end

    assign tok.char_code = cfg.invert ? pxa_pkg::RAMP_LIGHT[level] : pxa_pkg::RAMP_DARK[level];
    assign tok.eol       = eol_reg;
    assign tok.eoi       = eoi_reg;
    assign tok_valid     = (state_reg == ST_PUSH);

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        eol_next    = eol_reg;
        eoi_next    = eoi_reg;
        sq_next     = sq_reg;
        alpha_next  = alpha_reg;
        acc_next    = acc_reg;
        root_next   = root_reg;
        scaled_next = scaled_reg;
        bright_next = bright_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sq_next[0] = pxa_pkg::SQ_W'(pixel.red) * pxa_pkg::SQ_W'(pixel.red);
                    sq_next[1] = pxa_pkg::SQ_W'(pixel.green) * pxa_pkg::SQ_W'(pixel.green);
                    sq_next[2] = pxa_pkg::SQ_W'(pixel.blue) * pxa_pkg::SQ_W'(pixel.blue);
                    alpha_next = cfg.use_alpha ? pixel.alpha : '1;
                    acc_next   = '0;
                    step_next  = '0;
                    eol_next   = col_end;
                    eoi_next   = col_end && row_end;
                    if (col_end)
                    begin
                        col_next = '0;
                        row_next = row_end ? '0 : row_reg + pxa_pkg::POS_W'(1);
                    end
                    else
                    begin
                        col_next = col_reg + pxa_pkg::POS_W'(1);
                    end
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                acc_next = acc_reg + pxa_pkg::ACC_W'(pxa_pkg::WEIGHTS[mac_idx])
                                   * pxa_pkg::ACC_W'(sq_reg[mac_idx]);
                if (mac_idx == MIDX_W'(pxa_pkg::MAC_STEPS - 1))
                begin
                    step_next  = STEP_W'(pxa_pkg::Q_W - 1);
                    root_next  = '0;
                    state_next = ST_ROOT;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_ROOT:
            begin
                // one result bit per cycle, MSB first
                if (trial_sq <= acc_reg)
                begin
                    root_next = trial;
                end
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                scaled_next = pxa_pkg::SCALED_W'(root_reg) * pxa_pkg::SCALED_W'(alpha_reg);
                state_next  = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                // divide by 255 via reciprocal multiply
                bright_next = div_prod[pxa_pkg::DIV_SHIFT +: pxa_pkg::Q_W];
                state_next  = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (tok_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            eol_reg   <= 1'b0;
            eoi_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            eol_reg   <= eol_next;
            eoi_reg   <= eoi_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        sq_reg     <= sq_next;
        alpha_reg  <= alpha_next;
        acc_reg    <= acc_next;
        root_reg   <= root_next;
        scaled_reg <= scaled_next;
        bright_reg <= bright_next;
    end

endmodule

>>> rtl/pxa_fifo.sv
// ============================================================================
// pxa_fifo
// Small token queue between front and back.
// ============================================================================
module pxa_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  pxa_pkg::token_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output pxa_pkg::token_t pop_data
);

    localparam int PTR_W = (pxa_pkg::FIFO_DEPTH > 1) ? $clog2(pxa_pkg::FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(pxa_pkg::FIFO_DEPTH + 1);

    pxa_pkg::token_t  slot_reg [pxa_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(pxa_pkg::FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(pxa_pkg::FIFO_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(pxa_pkg::FIFO_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/pxa_back.sv
// ============================================================================
// pxa_back
// Expands each token into its character, optional newline and optional NUL,
// through a registered output stage.
// ============================================================================
module pxa_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tok_valid,
    output logic            tok_ready,
    input  pxa_pkg::token_t tok,
    output logic            ascii_valid,
    input  logic            ascii_ready,
    output pxa_pkg::ascii_t ascii
);

    logic            out_valid_reg, out_valid_next;
    pxa_pkg::ascii_t out_reg, out_next;
    logic            pend_nl_reg, pend_nl_next;
    logic            pend_nul_reg, pend_nul_next;
    logic            load;

    assign load        = !out_valid_reg || ascii_ready;
    assign tok_ready   = load && !pend_nl_reg && !pend_nul_reg;
    assign ascii_valid = out_valid_reg;
    assign ascii       = out_reg;

    // Next word: pending newline, pending NUL, then a fresh token
    always_comb
    begin
        out_valid_next = out_valid_reg && !ascii_ready;
        out_next       = out_reg;
        pend_nl_next   = pend_nl_reg;
        pend_nul_next  = pend_nul_reg;
        if (load)
        begin
            if (pend_nl_reg)
            begin
                out_valid_next     = 1'b1;
                out_next.char_code = pxa_pkg::CHAR_NL;
                out_next.last      = !pend_nul_reg;
                pend_nl_next       = 1'b0;
            end
            else if (pend_nul_reg)
            begin
                out_valid_next     = 1'b1;
                out_next.char_code = pxa_pkg::CHAR_NUL;
                out_next.last      = 1'b1;
                pend_nul_next      = 1'b0;
            end
            else if (tok_valid)
            begin
                out_valid_next     = 1'b1;
                out_next.char_code = tok.char_code;
                out_next.last      = !tok.eol;
                pend_nl_next       = tok.eol;
                pend_nul_next      = tok.eoi;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_nl_reg   <= 1'b0;
            pend_nul_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_nl_reg   <= pend_nl_next;
            pend_nul_reg  <= pend_nul_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

>>> rtl/pixel_to_ascii_mapper_core.sv
// ============================================================================
// pixel_to_ascii_mapper_core
// RGBA pixel stream to ASCII art: luminance ramp, newline per row, NUL per
// image, with an APB register port for geometry, invert and alpha use.
//
//   channel   | direction | handshake                 | word
//   ----------+-----------+---------------------------+-----------------
//   pixel     | in        | pixel_valid / pixel_ready | pixel_t (RGBA)
//   ascii     | out       | ascii_valid / ascii_ready | ascii_t
//   apb       | in        | psel / penable / pready   | 32-bit registers
//
// Pixels are handled one at a time: accept, 3 weighted-square MACs, a
// bit-serial square root on one 16x16 multiplier, alpha scale, divide, push.
// Words leave one per cycle while ascii_ready is high; 1 to 3 per pixel.
// A two-entry queue decouples the front from output stalls.
// Reset is asynchronous, active low; no clearing pass after reset.
// ============================================================================
module pixel_to_ascii_mapper_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pixel_valid,
    output logic                          pixel_ready,
    input  pxa_pkg::pixel_t               pixel,
    output logic                          ascii_valid,
    input  logic                          ascii_ready,
    output pxa_pkg::ascii_t               ascii,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pxa_pkg::PADDR_W-1:0]   paddr,
    input  logic [pxa_pkg::PDATA_W-1:0]   pwdata,
    output logic [pxa_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    pxa_pkg::cfg_t   cfg_reg, cfg_next;
    logic            wr_en;
    logic [pxa_pkg::REG_IDX_W-1:0] reg_idx;

    logic            fr_tok_valid, fr_tok_ready;
    pxa_pkg::token_t fr_tok;
    logic            bk_tok_valid, bk_tok_ready;
    pxa_pkg::token_t bk_tok;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[pxa_pkg::PADDR_W-1:2];

    // Register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                pxa_pkg::REG_ROW_WIDTH: cfg_next.row_width = pwdata[pxa_pkg::CFG_DIM_W-1:0];
                pxa_pkg::REG_ROW_COUNT: cfg_next.row_count = pwdata[pxa_pkg::CFG_DIM_W-1:0];
                pxa_pkg::REG_INVERT:    cfg_next.invert    = pwdata[0];
                pxa_pkg::REG_USE_ALPHA: cfg_next.use_alpha = pwdata[0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    // Register read
    always_comb
    begin
        case (reg_idx)
            pxa_pkg::REG_ROW_WIDTH: prdata = pxa_pkg::PDATA_W'(cfg_reg.row_width);
            pxa_pkg::REG_ROW_COUNT: prdata = pxa_pkg::PDATA_W'(cfg_reg.row_count);
            pxa_pkg::REG_INVERT:    prdata = pxa_pkg::PDATA_W'(cfg_reg.invert);
            pxa_pkg::REG_USE_ALPHA: prdata = pxa_pkg::PDATA_W'(cfg_reg.use_alpha);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_width <= pxa_pkg::CFG_DIM_W'(80);
            cfg_reg.row_count <= pxa_pkg::CFG_DIM_W'(24);
            cfg_reg.invert    <= 1'b0;
            cfg_reg.use_alpha <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pxa_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .tok_valid   (fr_tok_valid),
        .tok_ready   (fr_tok_ready),
        .tok         (fr_tok)
    );

    pxa_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_tok_valid),
        .push_ready (fr_tok_ready),
        .push_data  (fr_tok),
        .pop_valid  (bk_tok_valid),
        .pop_ready  (bk_tok_ready),
        .pop_data   (bk_tok)
    );

    pxa_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .tok_valid   (bk_tok_valid),
        .tok_ready   (bk_tok_ready),
        .tok         (bk_tok),
        .ascii_valid (ascii_valid),
        .ascii_ready (ascii_ready),
        .ascii       (ascii)
    );

endmodule

>>> rtl/pxa_checker.sv
// ============================================================================
// pxa_checker
// Port-level checks for the pixel to ASCII mapper, bound to the top level.
// ============================================================================
module pxa_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pixel_valid,
    input  logic                          pixel_ready,
    input  logic                          ascii_valid,
    input  logic                          ascii_ready,
    input  pxa_pkg::ascii_t               ascii
);

    // Stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ascii_valid && !ascii_ready |=> ascii_valid && $stable(ascii))
        else $error("output word changed while stalled");

    // One pixel in flight: ready drops after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> !pixel_ready)
        else $error("pixel accepted while previous still in work");

    // A non-final ramp character is followed at once by a newline
    a_char_then_nl: assert property (@(posedge clk) disable iff (!rst_n)
        ascii_valid && ascii_ready && !ascii.last
        && ascii.char_code != pxa_pkg::CHAR_NL
        |=> ascii_valid && ascii.char_code == pxa_pkg::CHAR_NL)
        else $error("row end without newline");

    // A non-final newline is followed at once by a final NUL
    a_nl_then_nul: assert property (@(posedge clk) disable iff (!rst_n)
        ascii_valid && ascii_ready && !ascii.last
        && ascii.char_code == pxa_pkg::CHAR_NL
        |=> ascii_valid && ascii.char_code == pxa_pkg::CHAR_NUL && ascii.last)
        else $error("image end without terminator");

endmodule

bind pixel_to_ascii_mapper_core pxa_checker u_pxa_checker (.*);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: pixel to ASCII mapper
// Drives RGBA pixel words into pixel_to_ascii_mapper_core and checks every
// ASCII word against an in-bench luminance predictor. Covers the register
// port, the ramp levels, alpha scaling, row and image framing, zero, oversize
// and shrunk geometry, random images under bursty input and output stalls,
// and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Luminance arithmetic: Q16 weights, Q8 brightness
    localparam longint unsigned LUMA_W_RED   = 19595;
    localparam longint unsigned LUMA_W_GREEN = 38470;
    localparam longint unsigned LUMA_W_BLUE  = 7471;
    localparam longint unsigned LEVEL_STEP   = 2551 * 256;
    localparam int              TOP_LEVEL    = 9;

    // Dark to light character ramp
    localparam logic [7:0] CHAR_RAMP [10] = '{"@", "%", "#", "*", "+", "=", "-", ":", ".", " "};
    localparam logic [6:0] NEWLINE_CODE = 7'h0A;
    localparam logic [6:0] NUL_CODE     = 7'h00;

    typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_e;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         pixel_valid;
    logic                         pixel_ready;
    pxa_pkg::pixel_t              pixel;
    logic                         ascii_valid;
    logic                         ascii_ready = 1'b0;
    pxa_pkg::ascii_t              ascii;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [pxa_pkg::PADDR_W-1:0]  paddr;
    logic [pxa_pkg::PDATA_W-1:0]  pwdata;
    logic [pxa_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    // Predictor state: register copy and raster position
    logic [12:0]         cfg_width  = 13'd80;
    logic [12:0]         cfg_rows   = 13'd24;
    logic                cfg_invert = 1'b0;
    logic                cfg_alpha  = 1'b0;
    int unsigned         col_pos    = 0;
    int unsigned         row_pos    = 0;

    pxa_pkg::ascii_t     expected_chars [$];
    pxa_pkg::ascii_t     want_word;
    int                  mismatch_count = 0;

    // Stimulus control
    rx_mode_e            rx_mode     = RX_FREE;
    int                  hold_cycles = 0;
    int unsigned         rx_phase    = 0;
    int                  burst_left  = 0;

    pixel_to_ascii_mapper_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .ascii_valid (ascii_valid),
        .ascii_ready (ascii_ready),
        .ascii       (ascii),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > v)
        begin
            probe = probe >> 2;
        end
        while (probe != 0)
        begin
            if (v >= root + probe)
            begin
                v    = v - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic int unsigned luma_level(input pxa_pkg::pixel_t p);
        longint unsigned r;
        longint unsigned g;
        longint unsigned b;
        longint unsigned a;
        longint unsigned q;
        longint unsigned lvl;
        r   = 64'(p.red);
        g   = 64'(p.green);
        b   = 64'(p.blue);
        a   = cfg_alpha ? 64'(p.alpha) : 64'd255;
        q   = isqrt64(LUMA_W_RED * r * r + LUMA_W_GREEN * g * g + LUMA_W_BLUE * b * b);
        q   = (q * a) / 255;
        lvl = (q * 100) / LEVEL_STEP;
        if (lvl > TOP_LEVEL)
        begin
            lvl = TOP_LEVEL;
        end
        return 32'(lvl);
    endfunction

    // Zero acts as one, oversize clamps
    function automatic int unsigned dim_limit(input logic [12:0] v);
        if (v == 13'd0)
        begin
            return 1;
        end
        if (32'(v) > 32'(pxa_pkg::MAX_DIM))
        begin
            return pxa_pkg::MAX_DIM;
        end
        return 32'(v);
    endfunction

    // Character, then newline at row end, then NUL at image end
    function automatic void predict_chars(input pxa_pkg::pixel_t p);
        pxa_pkg::ascii_t w;
        int unsigned     lvl;
        logic            eol;
        logic            eoi;
        lvl = luma_level(p);
        eol = (col_pos + 1 >= dim_limit(cfg_width));
        eoi = eol && (row_pos + 1 >= dim_limit(cfg_rows));
        w.char_code = cfg_invert ? CHAR_RAMP[TOP_LEVEL - lvl][6:0] : CHAR_RAMP[lvl][6:0];
        w.last      = !eol;
        expected_chars.push_back(w);
        if (eol)
        begin
            col_pos     = 0;
            w.char_code = NEWLINE_CODE;
            w.last      = !eoi;
            expected_chars.push_back(w);
            if (eoi)
            begin
                row_pos     = 0;
                w.char_code = NUL_CODE;
                w.last      = 1'b1;
                expected_chars.push_back(w);
            end
            else
            begin
                row_pos++;
            end
        end
        else
        begin
            col_pos++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what,
                 want, got);
        mismatch_count++;
    endtask

    // Compare each accepted output word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && ascii_valid && ascii_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch("unexpected word", 0, 32'(ascii));
            end
            else
            begin
                want_word = expected_chars.pop_front();
                if (ascii.char_code !== want_word.char_code)
                begin
                    report_mismatch("char_code", 32'(want_word.char_code),
                                    32'(ascii.char_code));
                end
                if (ascii.last !== want_word.last)
                begin
                    report_mismatch("last", 32'(want_word.last), 32'(ascii.last));
                end
            end
        end
    end

    // Output stalls: long hold-off first, else the selected pattern
    always @(posedge clk)
    begin
        rx_phase++;
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            ascii_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_FREE:    ascii_ready <= 1'b1;
                RX_RANDOM:  ascii_ready <= ($urandom_range(0, 2) != 0);
                default:    ascii_ready <= ((rx_phase % 7) < 4);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Present one pixel and hold it until accepted; valid stays high after
    task automatic send_pixel(input pxa_pkg::pixel_t p);
        pixel       <= p;
        pixel_valid <= 1'b1;
        do
            @(posedge clk);
        while (!pixel_ready);
        predict_chars(p);
    endtask

    task automatic pause_tx(input int n);
        if (n > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Bursts of random length with random gaps between them
    task automatic feed_pixel(input pxa_pkg::pixel_t p);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                pause_tx($urandom_range(1, 30));
            end
        end
        burst_left--;
        send_pixel(p);
    endtask

    // Stop sending until every expected word has come back
    task automatic drain();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [pxa_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (idx)
            pxa_pkg::REG_ROW_WIDTH: cfg_width  = value[12:0];
            pxa_pkg::REG_ROW_COUNT: cfg_rows   = value[12:0];
            pxa_pkg::REG_INVERT:    cfg_invert = value[0];
            pxa_pkg::REG_USE_ALPHA: cfg_alpha  = value[0];
            default:
            begin
            end
        endcase
    endtask

    task automatic read_reg_check(input logic [pxa_pkg::REG_IDX_W-1:0] idx);
        logic [31:0] want;
        logic [31:0] mask;
        case (idx)
            pxa_pkg::REG_ROW_WIDTH: want = 32'(cfg_width);
            pxa_pkg::REG_ROW_COUNT: want = 32'(cfg_rows);
            pxa_pkg::REG_INVERT:    want = 32'(cfg_invert);
            pxa_pkg::REG_USE_ALPHA: want = 32'(cfg_alpha);
            default:                want = 32'd0;
        endcase
        mask    = (idx == pxa_pkg::REG_ROW_WIDTH || idx == pxa_pkg::REG_ROW_COUNT)
                ? 32'h1FFF : 32'h1;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if ((prdata & mask) !== want)
        begin
            report_mismatch("register read", want, prdata & mask);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic [31:0] width, input logic [31:0] rows);
        write_reg(pxa_pkg::REG_ROW_WIDTH, width);
        write_reg(pxa_pkg::REG_ROW_COUNT, rows);
    endtask

    function automatic pxa_pkg::pixel_t make_pixel(input int r, input int g, input int b,
                                                   input int a);
        pxa_pkg::pixel_t p;
        p.red   = r[7:0];
        p.green = g[7:0];
        p.blue  = b[7:0];
        p.alpha = a[7:0];
        return p;
    endfunction

    // Mix of uniform, near-threshold gray and saturated components
    function automatic pxa_pkg::pixel_t random_pixel();
        pxa_pkg::pixel_t p;
        int              g;
        p = pxa_pkg::pixel_t'($urandom);
        case ($urandom_range(0, 3))
            0:
            begin
                g       = (2551 * $urandom_range(1, 9)) / 100 + $urandom_range(0, 1);
                p.red   = g[7:0];
                p.green = g[7:0];
                p.blue  = g[7:0];
            end
            1:
            begin
                p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                p.alpha = $urandom_range(0, 1) ? 8'hFF : p.alpha;
            end
            default:
            begin
            end
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register write/read-back, including bits beyond each field
    task automatic test_register_access();
        write_reg(pxa_pkg::REG_ROW_WIDTH, 32'hFFFF_E005);
        write_reg(pxa_pkg::REG_ROW_COUNT, 32'h0000_1FFF);
        write_reg(pxa_pkg::REG_INVERT, 32'hFFFF_FFFF);
        write_reg(pxa_pkg::REG_USE_ALPHA, 32'hFFFF_FFFE);
        read_reg_check(pxa_pkg::REG_ROW_WIDTH);
        read_reg_check(pxa_pkg::REG_ROW_COUNT);
        read_reg_check(pxa_pkg::REG_INVERT);
        read_reg_check(pxa_pkg::REG_USE_ALPHA);
    endtask

    // Red-only steps, then grays across the range, in a single-row image, both ramps
    task automatic test_ramp_levels();
        rx_mode = RX_FREE;
        set_geometry(11, 1);
        write_reg(pxa_pkg::REG_INVERT, 0);
        write_reg(pxa_pkg::REG_USE_ALPHA, 0);
        for (int k = 0; k <= 10; k++)
        begin
            send_pixel(make_pixel(k * 2551 / 100 + (k == 10 ? 0 : 1), 0, 0, 0));
        end
        drain();
        set_geometry(11, 1);
        write_reg(pxa_pkg::REG_INVERT, 1);
        for (int k = 0; k <= 10; k++)
        begin
            feed_pixel(make_pixel(k * 255 / 10, k * 255 / 10, k * 255 / 10, 8'hFF));
        end
        drain();
    endtask

    // Alpha scaling, and alpha ignored while alpha use is off
    task automatic test_alpha();
        rx_mode = RX_RANDOM;
        write_reg(pxa_pkg::REG_INVERT, 0);
        write_reg(pxa_pkg::REG_USE_ALPHA, 1);
        set_geometry(4, 2);
        feed_pixel(make_pixel(255, 255, 255, 0));
        feed_pixel(make_pixel(255, 255, 255, 255));
        feed_pixel(make_pixel(255, 255, 255, 128));
        feed_pixel(make_pixel(255, 0, 0, 255));
        drain();
        write_reg(pxa_pkg::REG_USE_ALPHA, 0);
        feed_pixel(make_pixel(255, 255, 255, 0));
        feed_pixel(make_pixel(0, 255, 0, 0));
        feed_pixel(make_pixel(0, 0, 255, 17));
        feed_pixel(make_pixel(0, 0, 0, 255));
        drain();
    endtask

    // Zero and oversize geometry, and sizes shrunk under the position
    task automatic test_geometry_edges();
        rx_mode = RX_PATTERN;
        set_geometry(0, 0);
        feed_pixel(make_pixel(10, 200, 30, 0));
        feed_pixel(make_pixel(255, 255, 255, 0));
        drain();
        set_geometry(8191, 4096);
        repeat (3) feed_pixel(random_pixel());
        drain();
        write_reg(pxa_pkg::REG_ROW_WIDTH, 2);
        feed_pixel(random_pixel());
        drain();
        set_geometry(1, 8191);
        repeat (2) feed_pixel(random_pixel());
        drain();
        write_reg(pxa_pkg::REG_ROW_COUNT, 1);
        feed_pixel(random_pixel());
        drain();
    endtask

    // Output held off for a long stretch while input keeps coming
    task automatic test_backpressure();
        rx_mode = RX_FREE;
        set_geometry(5, 3);
        hold_cycles = 300;
        repeat (24) send_pixel(random_pixel());
        drain();
    endtask

    // Random images; geometry and stall pattern change per phase
    task automatic test_random_images();
        int w;
        int h;
        int n;
        for (int phase = 0; phase < 6; phase++)
        begin
            drain();
            case ($urandom_range(0, 5))
                0:
                begin
                    w = 1;
                    h = 1;
                end
                1:
                begin
                    w = $urandom_range(0, 40);
                    h = $urandom_range(0, 3);
                end
                default:
                begin
                    w = $urandom_range(1, 8);
                    h = $urandom_range(1, 5);
                end
            endcase
            set_geometry(w, h);
            write_reg(pxa_pkg::REG_INVERT, $urandom_range(0, 1));
            write_reg(pxa_pkg::REG_USE_ALPHA, $urandom_range(0, 1));
            rx_mode = rx_mode_e'($urandom_range(0, 2));
            n = $urandom_range(40, 60);
            repeat (n) feed_pixel(random_pixel());
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n       = 1'b0;
        pixel_valid = 1'b0;
        pixel       = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_ramp_levels();
        test_alpha();
        test_geometry_edges();
        test_backpressure();
        test_random_images();

        drain();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && expected_chars.size() == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #5_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

>>> pixel_to_ascii_mapper_core.f
rtl/pxa_pkg.sv
rtl/pxa_front.sv
rtl/pxa_fifo.sv
rtl/pxa_back.sv
rtl/pixel_to_ascii_mapper_core.sv
rtl/pxa_checker.sv
dv/testbench.sv
